// File: rtl/assert_macros.svh
// Shared assertion forms for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: rtl/cwps_pkg.sv
`default_nettype none

package cwps_pkg;

  localparam int THREAD_SLOTS = 256;
  localparam int SLOT_W       = $clog2(THREAD_SLOTS);
  localparam int LEN_W        = $clog2(THREAD_SLOTS + 1);
  localparam int ID_W         = 8;
  localparam int ID_COUNT     = 2 ** ID_W;
  localparam int LEVELS       = 6;
  localparam int NUM_CREDIT   = 3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [2:0]        level_t;
  typedef logic [7:0]        credit_t;
  typedef credit_t [NUM_CREDIT-1:0] credit_vec_t;

  localparam level_t CREDIT_FIRST = 3'd2;
  localparam level_t CREDIT_LAST  = 3'd4;
  localparam level_t IDLE_LEVEL   = 3'd5;

  localparam slot_t SLOT_LAST = slot_t'(THREAD_SLOTS - 1);

  // Entry 0 is level two (interactive), entry 2 is level four (background).
  localparam credit_vec_t BASE_RESET = {8'd2, 8'd5, 8'd12};

  localparam logic [1:0] CFG_INTERACTIVE = 2'd0;
  localparam logic [1:0] CFG_NORMAL      = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND  = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQ_BACK,
    OP_ENQ_FRONT,
    OP_REMOVE,
    OP_PICK
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_QUEUED,
    STAT_NOT_QUEUED,
    STAT_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UNLINK,
    ST_FIXA,
    ST_FIXB,
    ST_DONE
  } state_t;

  typedef struct packed {
    slot_t next_slot;
    slot_t prev_slot;
  } link_t;

  typedef struct packed {
    logic   mark;
    level_t prio;
  } slot_info_t;

  typedef struct packed {
    logic        found;
    level_t      level;
    credit_vec_t credits;
  } pick_t;

  typedef slot_t wrap_table_t [ID_COUNT];

  function automatic level_t clamp_level(logic [2:0] v);
    return (v > IDLE_LEVEL) ? IDLE_LEVEL : v;
  endfunction

  function automatic wrap_table_t build_wrap();
    wrap_table_t t;
    for (int i = 0; i < ID_COUNT; i++) begin
      t[i] = slot_t'(i % THREAD_SLOTS);
    end
    return t;
  endfunction

  localparam wrap_table_t WRAP_TABLE = build_wrap();

endpackage

`default_nettype wire

// File: rtl/credit_weighted_priority_scheduler_top.sv
`default_nettype none
`include "assert_macros.svh"
// Ready-queue scheduler for thread slots over six priority levels.
// Input channel (in_valid / in_stall): one operation per beat - enqueue at
// back, forced enqueue at front, remove, or pick next. Output channel
// (out_valid / out_stall): exactly one result beat per operation, in order.
// Config port (cfg_we / cfg_index / cfg_data): base credit reloads for
// levels two to four; a write is registered and affects only the next
// refill. Write it only while the block is idle.
// The result is registered in the done state after the lookup state and any
// unlink and link-fix states; a rejected operation is fastest, a remove
// from mid-list slowest. A new operation is taken only back in idle; the
// sequencer walks the link RAM through one read port and one write port
// (read-modify-write of up to two neighbor entries).
// Reset: synchronous; all queues come up empty and the credit counters take
// the base register reset values. A clearing pass over every slot then
// wipes the queued marks; in_stall stays high during it.
// Stall: the result sits in the output register while out_stall is high; the
// next beat may already be accepted and is held finished until that result
// is taken.
module credit_weighted_priority_scheduler_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] thread_id,
  input  wire logic [2:0] priority_req,
  input  wire logic       running_valid,
  input  wire logic [2:0] running_priority,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [7:0]      picked_thread,
  output logic            picked_valid,
  output logic            preempt,
  output logic            any_ready,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cwps_pkg::state_t state;
  cwps_pkg::state_t state_next;

  cwps_pkg::op_t    cur_op;
  cwps_pkg::slot_t  cur_slot;
  cwps_pkg::level_t cur_prio;
  logic             cur_rv;
  cwps_pkg::level_t cur_rp;
  cwps_pkg::level_t cur_lv;

  cwps_pkg::status_t res_status;
  cwps_pkg::slot_t   res_picked;
  logic              res_pvalid;
  logic              res_preempt;

  logic            fix_b;
  cwps_pkg::slot_t fix_a_addr;
  cwps_pkg::slot_t fix_a_val;
  cwps_pkg::slot_t fix_b_addr;
  cwps_pkg::slot_t fix_b_val;

  cwps_pkg::slot_t     head [cwps_pkg::LEVELS];
  cwps_pkg::slot_t     tail [cwps_pkg::LEVELS];
  cwps_pkg::len_t      len  [cwps_pkg::LEVELS];
  cwps_pkg::credit_vec_t credits;
  cwps_pkg::credit_vec_t base;
  cwps_pkg::slot_t     clr_idx;

  logic [cwps_pkg::LEVELS-1:0] busy;
  cwps_pkg::pick_t             choice;
  cwps_pkg::slot_t             in_slot;

  logic                 link_we;
  cwps_pkg::slot_t      link_waddr;
  cwps_pkg::link_t      link_wdata;
  logic                 link_re;
  cwps_pkg::slot_t      link_raddr;
  cwps_pkg::link_t      link_rdata;
  logic                 slot_we;
  cwps_pkg::slot_t      slot_waddr;
  cwps_pkg::slot_info_t slot_wdata;
  logic                 slot_re;
  cwps_pkg::slot_info_t slot_rdata;

  logic is_enq;
  logic lv_empty;
  logic is_head;
  logic is_tail;
  logic out_load;

  function automatic logic [1:0] credit_idx(cwps_pkg::level_t lv);
    return 2'(lv - cwps_pkg::CREDIT_FIRST);
  endfunction

  cwps_ram #(
    .WIDTH ($bits(cwps_pkg::link_t)),
    .DEPTH (cwps_pkg::THREAD_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (link_re),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  cwps_ram #(
    .WIDTH ($bits(cwps_pkg::slot_info_t)),
    .DEPTH (cwps_pkg::THREAD_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_en   (slot_re),
    .rd_addr (in_slot),
    .rd_data (slot_rdata)
  );

  cwps_pick u_pick (
    .busy    (busy),
    .credits (credits),
    .base    (base),
    .choice  (choice)
  );

  always_comb begin
    for (int i = 0; i < cwps_pkg::LEVELS; i++) begin
      busy[i] = (len[i] != '0);
    end
  end

  assign in_slot  = cwps_pkg::WRAP_TABLE[thread_id];
  assign in_stall = (state != cwps_pkg::ST_IDLE);
  assign is_enq   = (cur_op == cwps_pkg::OP_ENQ_BACK) || (cur_op == cwps_pkg::OP_ENQ_FRONT);
  assign lv_empty = (len[cur_prio] == '0);
  assign is_head  = (cur_slot == head[cur_lv]);
  assign is_tail  = (cur_slot == tail[cur_lv]);
  assign out_load = (state == cwps_pkg::ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwps_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    link_we    = 1'b0;
    link_waddr = cur_slot;
    link_wdata = '0;
    link_re    = 1'b0;
    link_raddr = in_slot;
    slot_we    = 1'b0;
    slot_waddr = cur_slot;
    slot_wdata = '0;
    slot_re    = 1'b0;
    case (state)
      cwps_pkg::ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_idx;
        if (clr_idx == cwps_pkg::SLOT_LAST) begin
          state_next = cwps_pkg::ST_IDLE;
        end
      end
      cwps_pkg::ST_IDLE: begin
        if (in_valid) begin
          slot_re    = 1'b1;
          link_re    = 1'b1;
          state_next = cwps_pkg::ST_LOOK;
        end
      end
      cwps_pkg::ST_LOOK: begin
        state_next = cwps_pkg::ST_DONE;
        case (cur_op)
          cwps_pkg::OP_ENQ_BACK, cwps_pkg::OP_ENQ_FRONT: begin
            if (!slot_rdata.mark) begin
              slot_we    = 1'b1;
              slot_wdata = '{mark: 1'b1, prio: cur_prio};
              if (!lv_empty) begin
                link_we = 1'b1;
                link_re = 1'b1;
                if (cur_op == cwps_pkg::OP_ENQ_BACK) begin
                  link_wdata = '{next_slot: '0, prev_slot: tail[cur_prio]};
                  link_raddr = tail[cur_prio];
                  state_next = cwps_pkg::ST_FIXA;
                end else begin
                  link_wdata = '{next_slot: head[cur_prio], prev_slot: '0};
                  link_raddr = head[cur_prio];
                  state_next = cwps_pkg::ST_FIXB;
                end
              end
            end
          end
          cwps_pkg::OP_REMOVE: begin
            // Links of the slot were read at accept and are still held.
            if (slot_rdata.mark) begin
              state_next = cwps_pkg::ST_UNLINK;
            end
          end
          cwps_pkg::OP_PICK: begin
            if (choice.found) begin
              link_re    = 1'b1;
              link_raddr = head[choice.level];
              state_next = cwps_pkg::ST_UNLINK;
            end
          end
          default: begin
            state_next = cwps_pkg::ST_DONE;
          end
        endcase
      end
      cwps_pkg::ST_UNLINK: begin
        slot_we = 1'b1;
        if (!is_head) begin
          link_re    = 1'b1;
          link_raddr = link_rdata.prev_slot;
          state_next = cwps_pkg::ST_FIXA;
        end else if (!is_tail) begin
          link_re    = 1'b1;
          link_raddr = link_rdata.next_slot;
          state_next = cwps_pkg::ST_FIXB;
        end else begin
          state_next = cwps_pkg::ST_DONE;
        end
      end
      cwps_pkg::ST_FIXA: begin
        link_we    = 1'b1;
        link_waddr = fix_a_addr;
        link_wdata = '{next_slot: fix_a_val, prev_slot: link_rdata.prev_slot};
        if (fix_b) begin
          link_re    = 1'b1;
          link_raddr = fix_b_addr;
          state_next = cwps_pkg::ST_FIXB;
        end else begin
          state_next = cwps_pkg::ST_DONE;
        end
      end
      cwps_pkg::ST_FIXB: begin
        link_we    = 1'b1;
        link_waddr = fix_b_addr;
        link_wdata = '{next_slot: link_rdata.next_slot, prev_slot: fix_b_val};
        state_next = cwps_pkg::ST_DONE;
      end
      cwps_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = cwps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cwps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state: lengths, credits, base registers, flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < cwps_pkg::LEVELS; i++) begin
        len[i] <= '0;
      end
      credits <= cwps_pkg::BASE_RESET;
      base    <= cwps_pkg::BASE_RESET;
      clr_idx <= '0;
      fix_b   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cwps_pkg::CFG_INTERACTIVE: base[0] <= cfg_data;
          cwps_pkg::CFG_NORMAL:      base[1] <= cfg_data;
          cwps_pkg::CFG_BACKGROUND:  base[2] <= cfg_data;
          default: ;
        endcase
      end
      if (state == cwps_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == cwps_pkg::ST_LOOK) begin
        if (is_enq && !slot_rdata.mark) begin
          len[cur_prio] <= len[cur_prio] + 1'b1;
          fix_b <= (cur_op == cwps_pkg::OP_ENQ_FRONT) && !lv_empty;
          if (cur_op == cwps_pkg::OP_ENQ_FRONT &&
              cur_prio >= cwps_pkg::CREDIT_FIRST && cur_prio <= cwps_pkg::CREDIT_LAST &&
              credits[credit_idx(cur_prio)] == '0) begin
            credits[credit_idx(cur_prio)] <= 8'd1;
          end
        end
        // A refill counts even when the pick then finds nothing.
        if (cur_op == cwps_pkg::OP_PICK) begin
          credits <= choice.credits;
        end
      end
      if (state == cwps_pkg::ST_UNLINK) begin
        len[cur_lv] <= len[cur_lv] - 1'b1;
        fix_b       <= !is_tail;
      end
    end
  end

  // Item, result and list pointer registers.
  always_ff @(posedge clk) begin
    case (state)
      cwps_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_op      <= cwps_pkg::op_t'(opcode);
          cur_slot    <= in_slot;
          cur_prio    <= cwps_pkg::clamp_level(priority_req);
          cur_rv      <= running_valid;
          cur_rp      <= cwps_pkg::clamp_level(running_priority);
          res_status  <= cwps_pkg::STAT_OK;
          res_picked  <= '0;
          res_pvalid  <= 1'b0;
          res_preempt <= 1'b0;
        end
      end
      cwps_pkg::ST_LOOK: begin
        case (cur_op)
          cwps_pkg::OP_ENQ_BACK, cwps_pkg::OP_ENQ_FRONT: begin
            if (slot_rdata.mark) begin
              res_status <= cwps_pkg::STAT_QUEUED;
            end else begin
              fix_a_addr <= tail[cur_prio];
              fix_a_val  <= cur_slot;
              fix_b_addr <= head[cur_prio];
              fix_b_val  <= cur_slot;
              if (cur_op == cwps_pkg::OP_ENQ_BACK) begin
                tail[cur_prio] <= cur_slot;
                if (lv_empty) begin
                  head[cur_prio] <= cur_slot;
                end
                res_preempt <= cur_rv && (cur_prio < cur_rp) &&
                               (cur_prio < cwps_pkg::CREDIT_FIRST ||
                                (cur_prio <= cwps_pkg::CREDIT_LAST &&
                                 credits[credit_idx(cur_prio)] != '0));
              end else begin
                head[cur_prio] <= cur_slot;
                if (lv_empty) begin
                  tail[cur_prio] <= cur_slot;
                end
                res_preempt <= 1'b1;
              end
            end
          end
          cwps_pkg::OP_REMOVE: begin
            if (!slot_rdata.mark) begin
              res_status <= cwps_pkg::STAT_NOT_QUEUED;
            end else begin
              cur_lv <= cwps_pkg::clamp_level(slot_rdata.prio);
            end
          end
          cwps_pkg::OP_PICK: begin
            if (choice.found) begin
              cur_lv     <= choice.level;
              cur_slot   <= head[choice.level];
              res_picked <= head[choice.level];
              res_pvalid <= 1'b1;
            end else begin
              res_status <= cwps_pkg::STAT_EMPTY;
            end
          end
          default: ;
        endcase
      end
      cwps_pkg::ST_UNLINK: begin
        if (is_head) begin
          head[cur_lv] <= link_rdata.next_slot;
        end
        if (is_tail) begin
          tail[cur_lv] <= link_rdata.prev_slot;
        end
        fix_a_addr <= link_rdata.prev_slot;
        fix_a_val  <= link_rdata.next_slot;
        fix_b_addr <= link_rdata.next_slot;
        fix_b_val  <= link_rdata.prev_slot;
      end
      cwps_pkg::ST_DONE: begin
        if (out_load) begin
          status        <= res_status;
          picked_thread <= 8'(res_picked);
          picked_valid  <= res_pvalid;
          preempt       <= res_preempt;
          any_ready     <= |busy;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_reset_clears, clk, rst |=> state == cwps_pkg::ST_CLEAR, "no clear pass after reset")
  `ASSERT_RST(a_accept_look, clk, rst,
    in_valid && !in_stall |=> state == cwps_pkg::ST_LOOK, "accepted beat not looked up")
  `ASSERT_RST(a_unlink_nonempty, clk, rst,
    state == cwps_pkg::ST_UNLINK |-> len[cur_lv] != '0, "unlink from an empty level")
  `ASSERT_RST(a_fix_not_self, clk, rst,
    state == cwps_pkg::ST_FIXA |-> fix_a_addr != cur_slot, "link fix targets its own slot")
  `ASSERT_RST(a_pick_ok, clk, rst,
    out_valid && picked_valid |-> status == cwps_pkg::STAT_OK && !preempt,
    "picked beat with bad status")

endmodule

`default_nettype wire

// File: rtl/cwps_ram.sv
`default_nettype none

module cwps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cwps_pick.sv
`default_nettype none

module cwps_pick (
  input  wire logic [cwps_pkg::LEVELS-1:0] busy,
  input  wire cwps_pkg::credit_vec_t       credits,
  input  wire cwps_pkg::credit_vec_t       base,
  output cwps_pkg::pick_t                  choice
);

  logic cred_hit;
  logic base_hit;

  always_comb begin
    choice.found   = 1'b1;
    choice.level   = cwps_pkg::IDLE_LEVEL;
    choice.credits = credits;
    cred_hit       = 1'b0;
    base_hit       = 1'b0;
    if (busy[0]) begin
      choice.level = cwps_pkg::level_t'(0);
    end else if (busy[1]) begin
      choice.level = cwps_pkg::level_t'(1);
    end else begin
      for (int i = 0; i < cwps_pkg::NUM_CREDIT; i++) begin
        if (!cred_hit && busy[i + 2] && credits[i] != '0) begin
          cred_hit          = 1'b1;
          choice.level      = cwps_pkg::level_t'(i) + cwps_pkg::CREDIT_FIRST;
          choice.credits[i] = credits[i] - 1'b1;
        end
      end
      // No credited level with work has credit left: reload every counter and try once more.
      if (!cred_hit && (|busy[cwps_pkg::CREDIT_LAST:cwps_pkg::CREDIT_FIRST])) begin
        choice.credits = base;
        for (int i = 0; i < cwps_pkg::NUM_CREDIT; i++) begin
          if (!base_hit && busy[i + 2] && base[i] != '0) begin
            base_hit          = 1'b1;
            choice.level      = cwps_pkg::level_t'(i) + cwps_pkg::CREDIT_FIRST;
            choice.credits[i] = base[i] - 1'b1;
          end
        end
      end
      if (!cred_hit && !base_hit) begin
        if (busy[cwps_pkg::IDLE_LEVEL]) begin
          choice.level = cwps_pkg::IDLE_LEVEL;
        end else begin
          choice.found = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/cwps_result_checker.sv
`timescale 1ns / 100ps

module cwps_result_checker
  import cwps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] thread_id,
  input  logic [2:0] priority_req,
  input  logic       running_valid,
  input  logic [2:0] running_priority,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] status,
  input  logic [7:0] picked_thread,
  input  logic       picked_valid,
  input  logic       preempt,
  input  logic       any_ready,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         expect_count,
  output int         mismatches
);

  typedef struct {
    status_t st;
    slot_t   slot;
    logic    pvalid;
    logic    pre;
    logic    rdy;
  } sched_result_t;

  slot_t       link_next [THREAD_SLOTS];
  slot_t       link_prev [THREAD_SLOTS];
  level_t      slot_level [THREAD_SLOTS];
  logic        slot_queued [THREAD_SLOTS];
  slot_t       level_head [LEVELS];
  slot_t       level_tail [LEVELS];
  int unsigned level_depth [LEVELS];
  credit_t     credit_left [NUM_CREDIT];
  credit_t     credit_base [NUM_CREDIT];

  sched_result_t pending_results [$];
  int            errors = 0;

  function automatic level_t to_level(logic [2:0] v);
    return (v > IDLE_LEVEL) ? IDLE_LEVEL : level_t'(v);
  endfunction

  function automatic logic is_credited(level_t lv);
    return (lv >= CREDIT_FIRST) && (lv <= CREDIT_LAST);
  endfunction

  function automatic void clear_sched();
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      link_next[i]   = '0;
      link_prev[i]   = '0;
      slot_level[i]  = '0;
      slot_queued[i] = 1'b0;
    end
    for (int lv = 0; lv < LEVELS; lv++) begin
      level_head[lv]  = '0;
      level_tail[lv]  = '0;
      level_depth[lv] = 0;
    end
    for (int i = 0; i < NUM_CREDIT; i++) begin
      credit_base[i] = BASE_RESET[i];
      credit_left[i] = BASE_RESET[i];
    end
  endfunction

  function automatic void append_slot(level_t lv, slot_t s);
    if (level_depth[lv] == 0) begin
      level_head[lv] = s;
    end else begin
      link_next[level_tail[lv]] = s;
      link_prev[s] = level_tail[lv];
    end
    level_tail[lv] = s;
    level_depth[lv]++;
  endfunction

  function automatic void prepend_slot(level_t lv, slot_t s);
    if (level_depth[lv] == 0) begin
      level_tail[lv] = s;
    end else begin
      link_prev[level_head[lv]] = s;
      link_next[s] = level_head[lv];
    end
    level_head[lv] = s;
    level_depth[lv]++;
  endfunction

  function automatic void unlink_slot(level_t lv, slot_t s);
    if (s == level_head[lv]) begin
      level_head[lv] = link_next[s];
    end else begin
      link_next[link_prev[s]] = link_next[s];
    end
    if (s == level_tail[lv]) begin
      level_tail[lv] = link_prev[s];
    end else begin
      link_prev[link_next[s]] = link_prev[s];
    end
    level_depth[lv]--;
    slot_queued[s] = 1'b0;
  endfunction

  function automatic slot_t pop_head(level_t lv);
    slot_t s;
    s = level_head[lv];
    unlink_slot(lv, s);
    return s;
  endfunction

  // Take the first credited level that has work and credit left.
  function automatic logic take_credited(output slot_t s);
    s = '0;
    for (int lv = CREDIT_FIRST; lv <= CREDIT_LAST; lv++) begin
      if (level_depth[lv] != 0 && credit_left[lv - CREDIT_FIRST] != 0) begin
        credit_left[lv - CREDIT_FIRST]--;
        s = pop_head(level_t'(lv));
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic pick_slot(output slot_t s);
    logic credited_work;
    credited_work = 1'b0;
    s = '0;
    for (int lv = 0; lv < CREDIT_FIRST; lv++) begin
      if (level_depth[lv] != 0) begin
        s = pop_head(level_t'(lv));
        return 1'b1;
      end
    end
    if (take_credited(s)) return 1'b1;
    for (int lv = CREDIT_FIRST; lv <= CREDIT_LAST; lv++) begin
      if (level_depth[lv] != 0) credited_work = 1'b1;
    end
    if (credited_work) begin
      for (int i = 0; i < NUM_CREDIT; i++) credit_left[i] = credit_base[i];
      if (take_credited(s)) return 1'b1;
    end
    if (level_depth[IDLE_LEVEL] != 0) begin
      s = pop_head(IDLE_LEVEL);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic sched_result_t schedule_op(op_t op, logic [7:0] id_raw,
                                                logic [2:0] prio_raw, logic run_v,
                                                logic [2:0] run_prio_raw);
    sched_result_t r;
    level_t        p;
    level_t        rp;
    slot_t         s;
    slot_t         got;
    r  = '{st: STAT_OK, slot: '0, pvalid: 1'b0, pre: 1'b0, rdy: 1'b0};
    s  = slot_t'(id_raw % THREAD_SLOTS);
    p  = to_level(prio_raw);
    rp = to_level(run_prio_raw);
    case (op)
      OP_ENQ_BACK, OP_ENQ_FRONT: begin
        if (slot_queued[s]) begin
          r.st = STAT_QUEUED;
        end else begin
          slot_queued[s] = 1'b1;
          slot_level[s]  = p;
          if (op == OP_ENQ_FRONT) begin
            prepend_slot(p, s);
            // A forced entry into a drained credited level gets one credit.
            if (is_credited(p) && credit_left[p - CREDIT_FIRST] == 0)
              credit_left[p - CREDIT_FIRST] = 8'd1;
            r.pre = 1'b1;
          end else begin
            append_slot(p, s);
            if (run_v && p < rp &&
                (!is_credited(p) || credit_left[p - CREDIT_FIRST] != 0))
              r.pre = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (!slot_queued[s]) r.st = STAT_NOT_QUEUED;
        else unlink_slot(to_level(slot_level[s]), s);
      end
      default: begin
        if (pick_slot(got)) begin
          r.slot   = got;
          r.pvalid = 1'b1;
        end else begin
          r.st = STAT_EMPTY;
        end
      end
    endcase
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (level_depth[lv] != 0) r.rdy = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string what);
    errors++;
    $display("%0t: result mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      clear_sched();
      pending_results.delete();
    end else begin
      // Retire the result beat before predicting the new input beat.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report("result beat with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("status", 8'(status), 8'(want.st));
          check_field("picked_thread", picked_thread, want.slot);
          check_field("picked_valid", 8'(picked_valid), 8'(want.pvalid));
          check_field("preempt", 8'(preempt), 8'(want.pre));
          check_field("any_ready", 8'(any_ready), 8'(want.rdy));
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(schedule_op(op_t'(opcode), thread_id, priority_req,
                                              running_valid, running_priority));
      end
      if (cfg_we && cfg_index < NUM_CREDIT) credit_base[cfg_index] = cfg_data;
    end
    expect_count <= pending_results.size();
    mismatches   <= errors;
  end

endmodule

// File: tb/credit_weighted_priority_scheduler_top_tb.sv
`timescale 1ns / 100ps

module credit_weighted_priority_scheduler_top_tb;
  import cwps_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TICKS = 8;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] opcode;
  logic [7:0] thread_id;
  logic [2:0] priority_req;
  logic       running_valid;
  logic [2:0] running_priority;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status;
  logic [7:0] picked_thread;
  logic       picked_valid;
  logic       preempt;
  logic       any_ready;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int   expect_count;
  int   mismatches;
  int   cycle_count = 0;
  int   hold_left   = 0;
  logic steady      = 1'b0;
  logic hold_armed  = 1'b0;
  logic hold_used   = 1'b0;

  credit_weighted_priority_scheduler_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .thread_id        (thread_id),
    .priority_req     (priority_req),
    .running_valid    (running_valid),
    .running_priority (running_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .picked_thread    (picked_thread),
    .picked_valid     (picked_valid),
    .preempt          (preempt),
    .any_ready        (any_ready),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cwps_result_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .thread_id        (thread_id),
    .priority_req     (priority_req),
    .running_valid    (running_valid),
    .running_priority (running_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .picked_thread    (picked_thread),
    .picked_valid     (picked_valid),
    .preempt          (preempt),
    .any_ready        (any_ready),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .expect_count     (expect_count),
    .mismatches       (mismatches)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("credit_weighted_priority_scheduler_top_tb failed");
      $finish;
    end
  end

  // Result side: random stalls unless steady, one long hold-off when armed.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 32);
    end
  end

  task automatic send_op(op_t op, logic [7:0] id, logic [2:0] prio, logic run_v,
                         logic [2:0] run_prio);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    opcode           <= op;
    thread_id        <= id;
    priority_req     <= prio;
    running_valid    <= run_v;
    running_priority <= run_prio;
    @(posedge clk);
    // Hold the beat until it is taken.
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expect_count != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_credits(credit_t interactive, credit_t normal, credit_t background);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTERACTIVE;
    cfg_data  <= interactive;
    @(posedge clk);
    cfg_index <= CFG_NORMAL;
    cfg_data  <= normal;
    @(posedge clk);
    cfg_index <= CFG_BACKGROUND;
    cfg_data  <= background;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly live operations on a small pool of slots so that queues build up,
  // removes hit, and double enqueues occur; a quarter of the ids span all 8 bits.
  task automatic random_ops(int count);
    op_t        op;
    logic [7:0] id;
    int         r;
    repeat (count) begin
      r  = $urandom_range(99);
      op = (r < 35) ? OP_ENQ_BACK : (r < 47) ? OP_ENQ_FRONT :
           (r < 65) ? OP_REMOVE : OP_PICK;
      id = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(23));
      send_op(op, id, 3'($urandom_range(7)), 1'($urandom_range(1)),
              3'($urandom_range(7)));
    end
  endtask

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    opcode           = OP_ENQ_BACK;
    thread_id        = '0;
    priority_req     = '0;
    running_valid    = 1'b0;
    running_priority = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_INTERACTIVE;
    cfg_data         = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    // Wait out the clearing pass.
    while (in_stall) @(posedge clk);

    // Directed: reset credit values.
    send_op(OP_PICK,      8'h00, 3'd0, 1'b0, 3'd0);   // nothing ready
    send_op(OP_REMOVE,    8'hFF, 3'd7, 1'b1, 3'd7);   // not queued
    send_op(OP_ENQ_BACK,  8'h00, 3'd0, 1'b1, 3'd7);
    send_op(OP_ENQ_BACK,  8'h00, 3'd1, 1'b1, 3'd7);   // already queued
    send_op(OP_ENQ_FRONT, 8'hFF, 3'd7, 1'b0, 3'd0);   // beyond idle
    send_op(OP_ENQ_BACK,  8'h80, 3'd2, 1'b1, 3'd3);
    send_op(OP_ENQ_BACK,  8'h7F, 3'd3, 1'b1, 3'd6);
    send_op(OP_ENQ_BACK,  8'h55, 3'd4, 1'b1, 3'd5);
    send_op(OP_ENQ_BACK,  8'hAA, 3'd1, 1'b1, 3'd0);
    send_op(OP_ENQ_BACK,  8'h01, 3'd6, 1'b1, 3'd5);
    send_op(OP_ENQ_BACK,  8'h03, 3'd2, 1'b0, 3'd5);
    send_op(OP_ENQ_BACK,  8'h04, 3'd2, 1'b1, 3'd5);
    send_op(OP_ENQ_BACK,  8'h05, 3'd2, 1'b1, 3'd7);
    send_op(OP_REMOVE,    8'h04, 3'd0, 1'b0, 3'd0);   // middle of a list
    send_op(OP_REMOVE,    8'h05, 3'd0, 1'b0, 3'd0);   // tail
    send_op(OP_REMOVE,    8'h80, 3'd0, 1'b0, 3'd0);   // head
    send_op(OP_ENQ_FRONT, 8'h02, 3'd4, 1'b1, 3'd1);
    repeat (9) send_op(OP_PICK, 8'($urandom_range(255)), 3'd0, 1'b0, 3'd0);
    settle();

    // Drained credits: refills give nothing, forced entries get one credit.
    write_credits(8'd0, 8'd0, 8'd0);
    random_ops(PHASE_ITEMS);
    settle();

    steady <= 1'b1;
    write_credits(8'd255, 8'd255, 8'd255);
    random_ops(PHASE_ITEMS);
    settle();

    steady     <= 1'b0;
    hold_armed <= 1'b1;
    write_credits(8'd1, 8'd1, 8'd1);
    random_ops(PHASE_ITEMS);
    settle();

    write_credits(8'd3, 8'd0, 8'd7);
    random_ops(PHASE_ITEMS);
    settle();

    write_credits(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    random_ops(PHASE_ITEMS);
    settle();

    if (mismatches == 0 && expect_count == 0) begin
      $display("credit_weighted_priority_scheduler_top_tb passed");
    end else begin
      $display("credit_weighted_priority_scheduler_top_tb failed");
    end
    $finish;
  end

endmodule
